// ===== sv/thm_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, command and status types and saturation helper
// for the tridiagonal solver. No dependencies.
package thm_pkg;

  localparam int unsigned ROWS_MAX_DEF = 63;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned ROW_W        = 6;
  localparam int unsigned FRAC_W       = 16;
  localparam int unsigned NUM_W        = 64;
  localparam int unsigned QMAG_W       = 36;
  localparam int unsigned Q_W          = QMAG_W + 1;
  localparam int unsigned MUL_W        = DATA_W + 1;
  localparam int unsigned SATIN_W      = 40;

  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_AC   = 3'd1;
  localparam logic [2:0] MUL_AG   = 3'd2;
  localparam logic [2:0] MUL_GK   = 3'd3;
  localparam logic [2:0] MUL_BG   = 3'd4;
  localparam logic [2:0] MUL_BS   = 3'd5;

  localparam logic [2:0] DIV_NONE = 3'd0;
  localparam logic [2:0] DIV_PIVS = 3'd1;
  localparam logic [2:0] DIV_PPIV = 3'd2;
  localparam logic [2:0] DIV_PK   = 3'd3;
  localparam logic [2:0] DIV_BG   = 3'd4;
  localparam logic [2:0] DIV_BS   = 3'd5;

  localparam logic [2:0] UPD_NONE = 3'd0;
  localparam logic [2:0] UPD_BSUB = 3'd1;
  localparam logic [2:0] UPD_GSUB = 3'd2;
  localparam logic [2:0] UPD_GADD = 3'd3;
  localparam logic [2:0] UPD_PIV  = 3'd4;
  localparam logic [2:0] UPD_U    = 3'd5;

  typedef logic signed [DATA_W-1:0] val_t;

  typedef struct packed {
    logic       ovf;
    logic signed [DATA_W-1:0] val;
  } sat_t;

  typedef struct packed {
    logic       take;
    logic [2:0] mul_op;
    logic [2:0] div_op;
    logic [2:0] upd_op;
    logic       row_wr;
    logic       back_next;
    logic       emit_init;
    logic       emit_next;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic div_busy;
    logic mode;
    logic k_zero;
    logic last_eff;
    logic idx_one;
  } stat_t;

  function automatic sat_t sat_val(input logic signed [SATIN_W-1:0] v);
    sat_t r;
    logic signed [SATIN_W-1:0] hi;
    logic signed [SATIN_W-1:0] lo;
    hi = {{(SATIN_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    lo = ~hi;
    r.ovf = 1'b0;
    r.val = v[DATA_W-1:0];
    if (v > hi) begin
      r.ovf = 1'b1;
      r.val = hi[DATA_W-1:0];
    end else if (v < lo) begin
      r.ovf = 1'b1;
      r.val = lo[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/thm_chan_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for row words and solution words.
// Depends on thm_pkg.
interface thm_in_if;
  logic                       valid;
  logic                       ready;
  logic signed [thm_pkg::DATA_W-1:0] lower_entry;
  logic signed [thm_pkg::DATA_W-1:0] diag_entry;
  logic signed [thm_pkg::DATA_W-1:0] upper_entry;
  logic signed [thm_pkg::DATA_W-1:0] rhs_entry;
  logic                       last_row;
  modport source (output valid, lower_entry, diag_entry, upper_entry, rhs_entry, last_row,
                  input ready);
  modport sink (input valid, lower_entry, diag_entry, upper_entry, rhs_entry, last_row,
                output ready);
endinterface

interface thm_out_if;
  logic                       valid;
  logic                       ready;
  logic [thm_pkg::ROW_W-1:0]  row_index;
  logic signed [thm_pkg::DATA_W-1:0] solution_value;
  logic                       final_result;
  logic                       pivot_fault;
  modport source (output valid, row_index, solution_value, final_result, pivot_fault,
                  input ready);
  modport sink (input valid, row_index, solution_value, final_result, pivot_fault,
                output ready);
endinterface

// ===== sv/tridiagonal_thomas_solver.sv =====
`timescale 1ns / 1ps
// Top level of the tridiagonal (Thomas) solver: mode register, controller
// and datapath. Depends on thm_pkg, thm_chan_if, thm_ctrl, thm_dp.
//
//   port     dir   handshake      word
//   in_ch    in    valid/ready    lower, diag, upper, rhs entries, last_row
//   out_ch   out   valid/ready    row_index, solution_value, final/fault flags
//   cfg_*    in    write enable   solve_mode
//
// A general row runs two divisions, one multiply before each; a special row runs
// a division, then a multiply and a second division; the first row of a system
// runs no division (general) or one (special). The last row then runs back
// substitution row by row, then emits the solution words. The divider, one
// quotient bit per cycle, sets the row time; a saturating quotient ends early.
// Reset is synchronous, no clearing pass. A stalled output word holds; input
// stalls once the next back substitution reaches the output.
module tridiagonal_thomas_solver #(
  parameter int unsigned MAX_ROWS = thm_pkg::ROWS_MAX_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  thm_in_if.sink   in_ch,
  thm_out_if.source out_ch,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);

  logic           solve_mode_r;
  thm_pkg::cmd_t  cmd;
  thm_pkg::stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      solve_mode_r <= 1'b0;
    end else if (cfg_we) begin
      solve_mode_r <= cfg_wdata;
    end
  end

  thm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat(stat), .cmd(cmd));

  thm_dp #(.MAX_ROWS(MAX_ROWS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .mode(solve_mode_r),
    .lower_entry(in_ch.lower_entry), .diag_entry(in_ch.diag_entry),
    .upper_entry(in_ch.upper_entry), .rhs_entry(in_ch.rhs_entry),
    .last_row(in_ch.last_row), .stat(stat),
    .row_index(out_ch.row_index), .solution_value(out_ch.solution_value),
    .final_result(out_ch.final_result), .pivot_fault(out_ch.pivot_fault));

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("row accepted while previous row still in progress");

  a_div_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_busy |-> !in_ch.ready)
    else $error("input ready while divider busy");

  a_final_row_one: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_ch.valid && (out_ch.final_result == (out_ch.row_index == 6'd1)))
    else $error("final flag does not match row index");

endmodule

// ===== sv/thm_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module thm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 63,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/thm_div.sv =====
`timescale 1ns / 1ps
// Iterative signed divider, one quotient bit per cycle, rounds to nearest,
// saturates large quotients and flags a zero divisor. Depends on thm_pkg.
module thm_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [thm_pkg::NUM_W-1:0]   num,
  input  logic signed [thm_pkg::DATA_W-1:0]  den,
  output logic                               busy,
  output logic                               done,
  output logic                               zero_den,
  output logic signed [thm_pkg::Q_W-1:0]     quot
);

  localparam int unsigned QB    = thm_pkg::QMAG_W;
  localparam int unsigned DW    = thm_pkg::DATA_W;
  localparam int unsigned NW    = thm_pkg::NUM_W;
  localparam int unsigned QW    = thm_pkg::Q_W;
  localparam int unsigned CNT_W = $clog2(QB + 1);
  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_FIN  = 2'd2;
  localparam logic signed [QW-1:0] BIG = QW'(1) << (QB - 1);

  logic [1:0]          st_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                neg_r;
  logic                done_r;
  logic                zero_r;
  logic [DW-1:0]       md_r;
  logic [DW-1:0]       rem_r;
  logic [QB-1:0]       nsh_r;
  logic [QB-1:0]       q_r;
  logic signed [QW-1:0] quot_r;

  logic [NW-1:0] mn;
  logic [DW-1:0] md_in;
  logic          neg_in;
  logic          big;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [QW-1:0] mag;

  always_comb begin
    mn     = num[NW-1] ? NW'(-num) : NW'(num);
    md_in  = den[DW-1] ? DW'(-den) : DW'(den);
    neg_in = num[NW-1] ^ den[DW-1];
    big    = (mn >> (QB - 1)) >= NW'(md_in);
    trial  = {rem_r, nsh_r[QB-1]};
    ge     = trial >= {1'b0, md_r};
    diff   = trial - {1'b0, md_r};
    mag    = {1'b0, q_r} + ((rem_r >= (md_r - rem_r)) ? QW'(1) : QW'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        D_IDLE: begin
          if (start) begin
            neg_r  <= neg_in;
            md_r   <= md_in;
            zero_r <= 1'b0;
            if (md_in == '0) begin
              zero_r <= 1'b1;
              done_r <= 1'b1;
              if (num > 0) begin
                quot_r <= BIG;
              end else if (num < 0) begin
                quot_r <= -BIG;
              end else begin
                quot_r <= '0;
              end
            end else if (big) begin
              quot_r <= neg_in ? -BIG : BIG;
              done_r <= 1'b1;
            end else begin
              rem_r <= DW'(mn >> QB);
              nsh_r <= mn[QB-1:0];
              q_r   <= '0;
              cnt_r <= '0;
              st_r  <= D_RUN;
            end
          end
        end
        D_RUN: begin
          rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
          q_r   <= {q_r[QB-2:0], ge};
          nsh_r <= nsh_r << 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(QB - 1)) begin
            st_r <= D_FIN;
          end
        end
        D_FIN: begin
          quot_r <= neg_r ? -signed'(mag) : signed'(mag);
          done_r <= 1'b1;
          st_r   <= D_IDLE;
        end
        default: st_r <= D_IDLE;
      endcase
    end
  end

  assign busy     = st_r != D_IDLE;
  assign done     = done_r;
  assign zero_den = zero_r;
  assign quot     = quot_r;

endmodule

// ===== sv/thm_dp.sv =====
`timescale 1ns / 1ps
// Solver datapath: row registers, multiplier, divider, row and solution
// stores, counters and output word register. Depends on thm_pkg, thm_ram, thm_div.
module thm_dp #(
  parameter int unsigned MAX_ROWS = thm_pkg::ROWS_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  thm_pkg::cmd_t                      cmd,
  input  logic                               mode,
  input  logic signed [thm_pkg::DATA_W-1:0]  lower_entry,
  input  logic signed [thm_pkg::DATA_W-1:0]  diag_entry,
  input  logic signed [thm_pkg::DATA_W-1:0]  upper_entry,
  input  logic signed [thm_pkg::DATA_W-1:0]  rhs_entry,
  input  logic                               last_row,
  output thm_pkg::stat_t                     stat,
  output logic [thm_pkg::ROW_W-1:0]          row_index,
  output logic signed [thm_pkg::DATA_W-1:0]  solution_value,
  output logic                               final_result,
  output logic                               pivot_fault
);

  localparam int unsigned DW = thm_pkg::DATA_W;
  localparam int unsigned RW = thm_pkg::ROW_W;
  localparam int unsigned NW = thm_pkg::NUM_W;
  localparam int unsigned MW = thm_pkg::MUL_W;
  localparam int unsigned SW = thm_pkg::SATIN_W;
  localparam int unsigned QW = thm_pkg::Q_W;
  localparam int unsigned FW = thm_pkg::FRAC_W;
  localparam int unsigned AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic signed [DW-1:0] NEG_ONE = -(DW'(1) << FW);

  logic signed [DW-1:0] a_r, b_r, c_r, g_r;
  logic                 last_r;
  logic [RW-1:0]        k_r, idx_r, n_r;
  logic signed [DW-1:0] prev_piv_r, prev_rhs_r, prev_up_r, nsol_r;
  logic signed [NW-1:0] prod_r;
  logic                 fault_r;
  logic [RW-1:0]        oidx_r;
  logic signed [DW-1:0] osol_r;
  logic                 ofin_r, ofault_r;

  logic [DW-1:0] piv_rdata, rhs_rdata, up_rdata, sol_rdata;
  logic signed [DW-1:0] piv_rd, rhs_rd, up_rd, up_wr;
  logic [AW-1:0] k_addr, idx_addr;
  logic          sol_we;

  logic signed [MW-1:0]   ma, mb;
  logic signed [2*MW-1:0] prod_full;
  logic signed [NW-1:0]   div_num;
  logic signed [DW-1:0]   div_den;
  logic                   div_busy, div_done, div_zero;
  logic signed [QW-1:0]   quot;
  logic [RW:0]            kp1, kp2, ip1;
  logic signed [NW-1:0]   rhs_sh;
  logic signed [SW-1:0]   q_x, b_x, g_x, s_in;
  thm_pkg::sat_t          s_out;
  logic                   last_eff;

  assign piv_rd   = signed'(piv_rdata);
  assign rhs_rd   = signed'(rhs_rdata);
  assign up_rd    = signed'(up_rdata);
  assign up_wr    = mode ? NEG_ONE : c_r;
  assign k_addr   = AW'(k_r);
  assign idx_addr = AW'(idx_r - 1'b1);
  assign sol_we   = cmd.upd_op == thm_pkg::UPD_U;
  assign kp1      = (RW + 1)'(k_r) + 1'b1;
  assign kp2      = (RW + 1)'(k_r) + 2'd2;
  assign ip1      = (RW + 1)'(idx_r) + 1'b1;
  assign last_eff = last_r || (kp1 >= (RW + 1)'(MAX_ROWS));

  thm_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS)) u_piv_ram (
    .clk(clk), .we(cmd.row_wr), .waddr(k_addr), .wdata(b_r),
    .raddr(idx_addr), .rdata(piv_rdata));
  thm_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS)) u_rhs_ram (
    .clk(clk), .we(cmd.row_wr), .waddr(k_addr), .wdata(g_r),
    .raddr(idx_addr), .rdata(rhs_rdata));
  thm_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS)) u_up_ram (
    .clk(clk), .we(cmd.row_wr), .waddr(k_addr), .wdata(up_wr),
    .raddr(idx_addr), .rdata(up_rdata));
  thm_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS)) u_sol_ram (
    .clk(clk), .we(sol_we), .waddr(idx_addr), .wdata(s_out.val),
    .raddr(idx_addr), .rdata(sol_rdata));

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.mul_op)
      thm_pkg::MUL_AC: begin
        ma = {a_r[DW-1], a_r};
        mb = {prev_up_r[DW-1], prev_up_r};
      end
      thm_pkg::MUL_AG: begin
        ma = {a_r[DW-1], a_r};
        mb = {prev_rhs_r[DW-1], prev_rhs_r};
      end
      thm_pkg::MUL_GK: begin
        ma = {prev_rhs_r[DW-1], prev_rhs_r};
        mb = signed'(MW'(k_r));
      end
      thm_pkg::MUL_BG: begin
        ma = {up_rd[DW-1], up_rd};
        mb = {nsol_r[DW-1], nsol_r};
      end
      thm_pkg::MUL_BS: begin
        ma = {rhs_rd[DW-1], rhs_rd} + {nsol_r[DW-1], nsol_r};
        mb = signed'(MW'(idx_r));
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod_full = ma * mb;
  end

  always_comb begin
    rhs_sh  = {{(NW - DW - FW){rhs_rd[DW-1]}}, rhs_rd, {FW{1'b0}}};
    div_num = prod_r;
    div_den = prev_piv_r;
    unique case (cmd.div_op)
      thm_pkg::DIV_PIVS: begin
        div_num = signed'(NW'(kp2) << FW);
        div_den = signed'(DW'(kp1));
      end
      thm_pkg::DIV_PPIV: begin
        div_num = prod_r;
        div_den = prev_piv_r;
      end
      thm_pkg::DIV_PK: begin
        div_num = prod_r;
        div_den = signed'(DW'(kp1));
      end
      thm_pkg::DIV_BG: begin
        div_num = rhs_sh - prod_r;
        div_den = piv_rd;
      end
      thm_pkg::DIV_BS: begin
        div_num = prod_r;
        div_den = signed'(DW'(ip1));
      end
      default: begin
        div_num = prod_r;
        div_den = prev_piv_r;
      end
    endcase
  end

  thm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_op != thm_pkg::DIV_NONE),
    .num(div_num), .den(div_den), .busy(div_busy), .done(div_done),
    .zero_den(div_zero), .quot(quot));

  always_comb begin
    q_x = {{(SW - QW){quot[QW-1]}}, quot};
    b_x = {{(SW - DW){b_r[DW-1]}}, b_r};
    g_x = {{(SW - DW){g_r[DW-1]}}, g_r};
    unique case (cmd.upd_op)
      thm_pkg::UPD_BSUB: s_in = b_x - q_x;
      thm_pkg::UPD_GSUB: s_in = g_x - q_x;
      thm_pkg::UPD_GADD: s_in = g_x + q_x;
      default:           s_in = q_x;
    endcase
    s_out = thm_pkg::sat_val(s_in);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      fault_r <= 1'b0;
    end else begin
      if (cmd.take) begin
        a_r    <= lower_entry;
        b_r    <= diag_entry;
        c_r    <= upper_entry;
        g_r    <= rhs_entry;
        last_r <= last_row;
        if (k_r == '0) begin
          fault_r <= 1'b0;
        end
      end
      if (cmd.mul_op != thm_pkg::MUL_NONE) begin
        prod_r <= prod_full[NW-1:0];
      end
      if (cmd.upd_op != thm_pkg::UPD_NONE) begin
        fault_r <= fault_r | s_out.ovf | div_zero;
        unique case (cmd.upd_op)
          thm_pkg::UPD_BSUB, thm_pkg::UPD_PIV: b_r <= s_out.val;
          thm_pkg::UPD_GSUB, thm_pkg::UPD_GADD: g_r <= s_out.val;
          thm_pkg::UPD_U: nsol_r <= s_out.val;
          default: nsol_r <= nsol_r;
        endcase
      end
      if (cmd.row_wr) begin
        prev_piv_r <= b_r;
        prev_rhs_r <= g_r;
        prev_up_r  <= up_wr;
        if (last_eff) begin
          k_r    <= '0;
          idx_r  <= RW'(kp1);
          n_r    <= RW'(kp1);
          nsol_r <= '0;
        end else begin
          k_r <= RW'(kp1);
        end
      end
      if (cmd.back_next || cmd.emit_next) begin
        idx_r <= idx_r - 1'b1;
      end
      if (cmd.emit_init) begin
        idx_r <= n_r;
      end
      if (cmd.out_load) begin
        oidx_r   <= idx_r;
        osol_r   <= signed'(sol_rdata);
        ofin_r   <= idx_r == RW'(1);
        ofault_r <= fault_r;
      end
    end
  end

  assign stat.div_done = div_done;
  assign stat.div_busy = div_busy;
  assign stat.mode     = mode;
  assign stat.k_zero   = k_r == '0;
  assign stat.last_eff = last_eff;
  assign stat.idx_one  = idx_r == RW'(1);

  assign row_index      = oidx_r;
  assign solution_value = osol_r;
  assign final_result   = ofin_r;
  assign pivot_fault    = ofault_r;

endmodule

// ===== sv/thm_ctrl.sv =====
`timescale 1ns / 1ps
// Solver controller: sequences elimination, back substitution and word
// output, and owns both handshakes. Depends on thm_pkg.
module thm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  thm_pkg::stat_t stat,
  output thm_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ROW  = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_DIV1 = 4'd3;
  localparam logic [3:0] S_W1   = 4'd4;
  localparam logic [3:0] S_MUL2 = 4'd5;
  localparam logic [3:0] S_DIV2 = 4'd6;
  localparam logic [3:0] S_W2   = 4'd7;
  localparam logic [3:0] S_WR   = 4'd8;
  localparam logic [3:0] S_BRD  = 4'd9;
  localparam logic [3:0] S_BMUL = 4'd10;
  localparam logic [3:0] S_BDIV = 4'd11;
  localparam logic [3:0] S_BW   = 4'd12;
  localparam logic [3:0] S_ERD  = 4'd13;
  localparam logic [3:0] S_EOUT = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = state_r == S_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_ROW;
        end
      end
      S_ROW: begin
        if (stat.mode) begin
          cmd.div_op = thm_pkg::DIV_PIVS;
          state_nxt  = S_W1;
        end else if (stat.k_zero) begin
          state_nxt = S_WR;
        end else begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul_op = thm_pkg::MUL_AC;
        state_nxt  = S_DIV1;
      end
      S_DIV1: begin
        cmd.div_op = thm_pkg::DIV_PPIV;
        state_nxt  = S_W1;
      end
      S_W1: begin
        if (stat.div_done) begin
          cmd.upd_op = stat.mode ? thm_pkg::UPD_PIV : thm_pkg::UPD_BSUB;
          state_nxt  = (stat.mode && stat.k_zero) ? S_WR : S_MUL2;
        end
      end
      S_MUL2: begin
        cmd.mul_op = stat.mode ? thm_pkg::MUL_GK : thm_pkg::MUL_AG;
        state_nxt  = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_op = stat.mode ? thm_pkg::DIV_PK : thm_pkg::DIV_PPIV;
        state_nxt  = S_W2;
      end
      S_W2: begin
        if (stat.div_done) begin
          cmd.upd_op = stat.mode ? thm_pkg::UPD_GADD : thm_pkg::UPD_GSUB;
          state_nxt  = S_WR;
        end
      end
      S_WR: begin
        cmd.row_wr = 1'b1;
        state_nxt  = stat.last_eff ? S_BRD : S_IDLE;
      end
      S_BRD: state_nxt = S_BMUL;
      S_BMUL: begin
        cmd.mul_op = stat.mode ? thm_pkg::MUL_BS : thm_pkg::MUL_BG;
        state_nxt  = S_BDIV;
      end
      S_BDIV: begin
        cmd.div_op = stat.mode ? thm_pkg::DIV_BS : thm_pkg::DIV_BG;
        state_nxt  = S_BW;
      end
      S_BW: begin
        if (stat.div_done) begin
          cmd.upd_op = thm_pkg::UPD_U;
          if (stat.idx_one) begin
            cmd.emit_init = 1'b1;
            state_nxt     = S_ERD;
          end else begin
            cmd.back_next = 1'b1;
            state_nxt     = S_BRD;
          end
        end
      end
      S_ERD: state_nxt = S_EOUT;
      S_EOUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          if (stat.idx_one) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_nxt     = S_ERD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
